// ===== rtl/bfdh_pkg.sv =====
`timescale 1ns / 1ps
package bfdh_pkg;

   localparam int HASH_W  = 64;
   localparam int POS_W   = 21;
   localparam int NH_W    = 8;
   localparam int CNT_W   = 32;
   localparam int CMD_W   = 2;
   localparam int DCNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   localparam logic CSR_NUM_HASHES    = 1'b0;
   localparam logic CSR_FILTER_LENGTH = 1'b1;

   localparam logic [NH_W-1:0]  NUM_HASHES_RST    = 8'd7;
   localparam logic [POS_W-1:0] FILTER_LENGTH_RST = 21'd1048576;

   typedef struct packed {
      logic start;
   } div_ctl_type;

endpackage

// ===== rtl/bfdh_ram.sv =====
`timescale 1ns / 1ps
module bfdh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16384,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bfdh_div.sv =====
`timescale 1ns / 1ps
// restoring remainder unit, one dividend bit per cycle
module bfdh_div import bfdh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [HASH_W-1:0] dividend,
   input  logic [POS_W-1:0]  divisor,
   output logic              done,
   output logic [POS_W-1:0]  remainder
);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [HASH_W-1:0] num_ff, num_in;
   logic [POS_W-1:0]  rem_ff, rem_in;
   logic [POS_W-1:0]  den_ff, den_in;
   logic [POS_W:0]    trial;
   logic [POS_W:0]    diff;
   logic              ge;

   always_comb begin
      trial = {rem_ff, num_ff[HASH_W-1]};
      diff  = trial - {1'b0, den_ff};
      ge    = trial >= {1'b0, den_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (ctl.start) begin
         run_in = 1'b1;
         num_in = dividend;
         rem_in = '0;
         den_in = divisor;
         cnt_in = DCNT_W'(HASH_W);
      end else if (run_ff) begin
         num_in = {num_ff[HASH_W-2:0], 1'b0};
         rem_in = ge ? diff[POS_W-1:0] : trial[POS_W-1:0];
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/bloom_filter_double_hash.sv =====
`timescale 1ns / 1ps
// Bloom filter with double hashing over an on-chip bit store. An item is taken when start is
// high and busy is low; its single result appears on the rsp_ ports for one cycle with
// rsp_valid, and the receiver cannot stall it. Add and query walk the probes one at a time
// through one shared restoring divider: each probe takes a 64-step modulo by the filter
// length, then the position is split into word and bit and the word is read, and a check
// step tests or sets the bit; busy stays high until the last probe is done (a query stops
// at its first clear bit). Items with no probes and unused commands are answered from idle.
// Clear, and the sweep that follows reset, write zeros through the store one word per cycle;
// busy stays high until the last word is written.
module bloom_filter_double_hash import bfdh_pkg::*; #(
   parameter int STORE_WORDS = 16384,
   parameter int WORD_BITS   = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [CMD_W-1:0]  req_command,
   input  logic [HASH_W-1:0] req_hash_a,
   input  logic [HASH_W-1:0] req_hash_b,
   output logic              rsp_valid,
   output logic              rsp_possibly_present,
   output logic [CNT_W-1:0]  rsp_added_count,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [POS_W-1:0]  csr_wdata
);

   localparam int AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
   localparam int SW = $clog2(WORD_BITS);
   localparam logic [63:0] CAPACITY = 64'(STORE_WORDS) * 64'(WORD_BITS);
   // word index by reciprocal multiplication, exact for any POS_W-bit position
   localparam int RSH = POS_W + SW;
   localparam logic [63:0] RECIP_W =
      ((64'd1 << RSH) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
   localparam logic [POS_W:0] RECIP = RECIP_W[POS_W:0];

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CLEAR = 3'd1;
   localparam logic [2:0] S_MOD   = 3'd2;
   localparam logic [2:0] S_SPLIT = 3'd3;
   localparam logic [2:0] S_CHECK = 3'd4;

   logic [2:0]           state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [HASH_W-1:0]    h_ff, h_in;
   logic [HASH_W-1:0]    b_ff, b_in;
   logic [NH_W-1:0]      probe_ff, probe_in;
   logic [NH_W-1:0]      nh_ff;
   logic [POS_W-1:0]     flen_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   logic [AW-1:0]        word_ff, word_in;
   logic [SW-1:0]        bit_ff, bit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_present_ff, rsp_present_in;

   logic [POS_W-1:0]     eff_len;
   logic [POS_W-1:0]     len_nz;
   logic [2*POS_W:0]     split_prod;
   div_ctl_type          div_ctl;
   logic [HASH_W-1:0]    div_dividend;
   logic [POS_W-1:0]     div_divisor;
   logic                 div_done;
   logic [POS_W-1:0]     div_rem;
   logic                 ram_we;
   logic [AW-1:0]        ram_waddr;
   logic [WORD_BITS-1:0] ram_wdata;
   logic                 ram_re;
   logic [WORD_BITS-1:0] ram_rdata;
   logic                 accept;
   logic                 last_probe;
   logic                 miss;

   always_comb begin
      len_nz  = (flen_ff == '0) ? POS_W'(1) : flen_ff;
      eff_len = (64'(len_nz) > CAPACITY) ? CAPACITY[POS_W-1:0] : len_nz;
      split_prod = (2*POS_W+1)'(div_rem) * (2*POS_W+1)'(RECIP);
   end

   assign accept     = start && !busy;
   assign last_probe = (probe_ff + NH_W'(1)) == nh_ff;
   assign miss       = !ram_rdata[bit_ff];

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      h_in           = h_ff;
      b_in           = b_ff;
      probe_in       = probe_ff;
      count_in       = count_ff;
      clr_addr_in    = clr_addr_ff;
      clr_rsp_in     = clr_rsp_ff;
      word_in        = word_ff;
      bit_in         = bit_ff;
      rsp_valid_in   = 1'b0;
      rsp_present_in = rsp_present_ff;
      div_ctl        = '0;
      div_dividend   = req_hash_a;
      div_divisor    = eff_len;
      ram_we         = 1'b0;
      ram_waddr      = clr_addr_ff;
      ram_wdata      = '0;
      ram_re         = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_command;
               h_in     = req_hash_a;
               b_in     = req_hash_b;
               probe_in = '0;
               case (req_command)
                  CMD_ADD, CMD_QUERY: begin
                     if (nh_ff == '0) begin
                        rsp_valid_in   = 1'b1;
                        rsp_present_in = (req_command == CMD_QUERY);
                        if (req_command == CMD_ADD && count_ff != '1) begin
                           count_in = count_ff + CNT_W'(1);
                        end
                     end else begin
                        div_ctl.start = 1'b1;
                        state_in      = S_MOD;
                     end
                  end
                  CMD_CLEAR: begin
                     count_in    = '0;
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = S_CLEAR;
                  end
                  default: begin
                     rsp_valid_in   = 1'b1;
                     rsp_present_in = 1'b0;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(STORE_WORDS - 1)) begin
               state_in       = S_IDLE;
               rsp_valid_in   = clr_rsp_ff;
               rsp_present_in = 1'b0;
               clr_rsp_in     = 1'b0;
            end
         end
         S_MOD: begin
            if (div_done) begin
               word_in  = AW'(split_prod >> RSH);
               state_in = S_SPLIT;
            end
         end
         S_SPLIT: begin
            ram_re   = 1'b1;
            bit_in   = SW'(div_rem - POS_W'(word_ff) * POS_W'(WORD_BITS));
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cmd_ff == CMD_ADD) begin
               ram_we    = 1'b1;
               ram_waddr = word_ff;
               ram_wdata = ram_rdata | (WORD_BITS'(1) << bit_ff);
            end
            if ((cmd_ff == CMD_QUERY && miss) || last_probe) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_present_in = (cmd_ff == CMD_QUERY) && !miss;
               if (cmd_ff == CMD_ADD && count_ff != '1) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end else begin
               probe_in      = probe_ff + NH_W'(1);
               h_in          = h_ff + b_ff;
               div_ctl.start = 1'b1;
               div_dividend  = h_ff + b_ff;
               state_in      = S_MOD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         nh_ff        <= NUM_HASHES_RST;
         flen_ff      <= FILTER_LENGTH_RST;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NUM_HASHES:    nh_ff   <= csr_wdata[NH_W-1:0];
               CSR_FILTER_LENGTH: flen_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      cmd_ff         <= cmd_in;
      h_ff           <= h_in;
      b_ff           <= b_in;
      probe_ff       <= probe_in;
      word_ff        <= word_in;
      bit_ff         <= bit_in;
      rsp_present_ff <= rsp_present_in;
   end

   bfdh_div u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   bfdh_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (word_ff),
      .rd_data (ram_rdata)
   );

   assign busy                 = state_ff != S_IDLE;
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_possibly_present = rsp_present_ff;
   assign rsp_added_count      = count_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_probe_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (req_command == CMD_ADD || req_command == CMD_QUERY) && nh_ff != '0 |=> busy)
      else $error("probe item did not start");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_MOD)
      else $error("divider finished outside a probe");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || (state_ff == S_CHECK && cmd_ff == CMD_ADD)))
      else $error("unexpected store write");

   a_query_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_possibly_present |-> $past(cmd_ff == CMD_QUERY || accept))
      else $error("present flag on a non-query item");

endmodule

// ===== test/tb_bloom_filter_double_hash.sv =====
`timescale 1ns / 1ps
module tb_bloom_filter_double_hash;
   import bfdh_pkg::*;

   localparam int STORE_WORDS = 16384;
   localparam int WORD_BITS   = 64;
   localparam logic [HASH_W-1:0] CAPACITY = 64'(STORE_WORDS) * 64'(WORD_BITS);
   localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
   } bloom_cmd_type;

   typedef struct {
      logic             present;
      logic [CNT_W-1:0] count;
   } bloom_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_command = CMD_ADD;
   logic [HASH_W-1:0] req_hash_a = '0;
   logic [HASH_W-1:0] req_hash_b = '0;
   logic              rsp_valid;
   logic              rsp_possibly_present;
   logic [CNT_W-1:0]  rsp_added_count;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_NUM_HASHES;
   logic [POS_W-1:0]  csr_wdata = '0;

   // filter image: set bits only, keyed by position
   bit                filt_bits [logic [HASH_W-1:0]];
   logic [CNT_W-1:0]  filt_count = '0;
   logic [NH_W-1:0]   cfg_probes = NUM_HASHES_RST;
   logic [POS_W-1:0]  cfg_length = FILTER_LENGTH_RST;

   bloom_cmd_type     cmd_q [$];
   bloom_rsp_type     resp_due_q [$];
   logic [127:0]      key_pool [$];
   bloom_cmd_type     drv_item;
   bloom_rsp_type     mon_due;
   int                gap_pct = 0;
   int                err_count = 0;
   int                clears_left = 8;

   bloom_filter_double_hash #(
      .STORE_WORDS(STORE_WORDS),
      .WORD_BITS  (WORD_BITS)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_hash_a          (req_hash_a),
      .req_hash_b          (req_hash_b),
      .rsp_valid           (rsp_valid),
      .rsp_possibly_present(rsp_possibly_present),
      .rsp_added_count     (rsp_added_count),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic bloom_rsp_type bloom_predict(logic [CMD_W-1:0] cmd,
                                                   logic [HASH_W-1:0] a,
                                                   logic [HASH_W-1:0] b);
      bloom_rsp_type     r;
      logic [HASH_W-1:0] len;
      logic [HASH_W-1:0] acc;
      logic [HASH_W-1:0] pos;
      len = {{(HASH_W-POS_W){1'b0}}, cfg_length};
      if (len == 0) len = 1;
      if (len > CAPACITY) len = CAPACITY;
      r.present = 1'b0;
      acc = a;
      case (cmd)
         CMD_ADD: begin
            for (int n = 0; n < cfg_probes; n++) begin
               pos = acc % len;
               filt_bits[pos] = 1'b1;
               acc = acc + b;
            end
            if (filt_count != '1) filt_count = filt_count + 1;
         end
         CMD_QUERY: begin
            r.present = 1'b1;
            for (int n = 0; n < cfg_probes; n++) begin
               pos = acc % len;
               if (!filt_bits.exists(pos)) begin
                  r.present = 1'b0;
                  break;
               end
               acc = acc + b;
            end
         end
         CMD_CLEAR: begin
            filt_bits.delete();
            filt_count = '0;
         end
         default: ;
      endcase
      r.count = filt_count;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            resp_due_q.push_back(bloom_predict(req_command, req_hash_a, req_hash_b));
         if (!start || !busy) begin
            if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
               drv_item = cmd_q.pop_front();
               start <= 1'b1;
               req_command <= drv_item.cmd;
               req_hash_a <= drv_item.a;
               req_hash_b <= drv_item.b;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   task automatic flag_mismatch(string what);
      err_count++;
      if (err_count <= 10) $display("mismatch: %s", what);
   endtask

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (resp_due_q.size() == 0) begin
            flag_mismatch($sformatf("result with none due: present %0b count %0d",
                                    rsp_possibly_present, rsp_added_count));
         end else begin
            mon_due = resp_due_q.pop_front();
            if (rsp_possibly_present !== mon_due.present)
               flag_mismatch($sformatf("possibly_present exp %0b got %0b",
                                       mon_due.present, rsp_possibly_present));
            else if (rsp_added_count !== mon_due.count)
               flag_mismatch($sformatf("added_count exp %0d got %0d",
                                       mon_due.count, rsp_added_count));
         end
      end
   end

   function automatic logic [HASH_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_item(logic [CMD_W-1:0] cmd, logic [HASH_W-1:0] a,
                             logic [HASH_W-1:0] b);
      bloom_cmd_type it;
      it.cmd = cmd;
      it.a = a;
      it.b = b;
      cmd_q.push_back(it);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (cmd_q.size() != 0 || start || resp_due_q.size() != 0 || busy);
   endtask

   task automatic write_reg(logic idx, logic [POS_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == CSR_NUM_HASHES) cfg_probes = val[NH_W-1:0];
      else cfg_length = val;
   endtask

   task automatic set_config(logic [NH_W-1:0] probes, logic [POS_W-1:0] len);
      logic [POS_W-1:0] noise;
      noise = POS_W'($urandom);
      write_reg(CSR_NUM_HASHES, {noise[POS_W-1:NH_W], probes});
      write_reg(CSR_FILTER_LENGTH, len);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_random(int n_items);
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      logic [127:0]      k;
      int                roll;
      for (int i = 0; i < n_items; i++) begin
         roll = $urandom_range(99);
         a = rand64();
         b = ($urandom_range(15) == 0) ? '0 : rand64();
         if (roll < 2 && clears_left > 0) begin
            clears_left--;
            queue_item(CMD_CLEAR, a, b);
            key_pool.delete();
         end else if (roll < 4) begin
            queue_item(CMD_NONE, a, b);
         end else if (roll < 46) begin
            queue_item(CMD_ADD, a, b);
            if (key_pool.size() < 32) key_pool.push_back({a, b});
            else key_pool[$urandom_range(31)] = {a, b};
         end else if (roll < 86 && key_pool.size() != 0) begin
            k = key_pool[$urandom_range(key_pool.size() - 1)];
            queue_item(CMD_QUERY, k[127:64], k[63:0]);
         end else begin
            queue_item(CMD_QUERY, a, b);
         end
      end
   endtask

   initial begin
      logic [HASH_W-1:0] a;
      logic [HASH_W-1:0] b;
      logic [POS_W-1:0]  len;
      int                gaps [3];
      gaps = '{0, 62, 33};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // reset settings
      queue_item(CMD_QUERY, '0, '0);
      queue_item(CMD_ADD, '0, '0);
      queue_item(CMD_QUERY, '0, '0);
      queue_item(CMD_ADD, '1, '1);
      queue_item(CMD_QUERY, '1, '1);
      queue_item(CMD_QUERY, 64'd1, 64'd5);
      queue_item(CMD_NONE, '1, '1);
      queue_item(CMD_CLEAR, '1, '1);
      queue_item(CMD_QUERY, '0, '0);
      queue_item(CMD_ADD, '0, '0);
      wait_idle();

      // zero probes, zero length
      set_config('0, '0);
      gap_pct = 33;
      queue_item(CMD_QUERY, rand64(), rand64());
      queue_item(CMD_ADD, rand64(), rand64());
      queue_item(CMD_QUERY, rand64(), rand64());
      wait_idle();

      // most probes, length past capacity
      set_config('1, '1);
      a = rand64();
      b = rand64();
      queue_item(CMD_ADD, a, b);
      queue_item(CMD_QUERY, a, b);
      queue_item(CMD_QUERY, rand64(), rand64());
      wait_idle();

      // single-bit filter
      set_config(8'd1, 21'd1);
      gap_pct = 62;
      queue_item(CMD_CLEAR, '0, '0);
      queue_item(CMD_QUERY, rand64(), rand64());
      queue_item(CMD_ADD, rand64(), rand64());
      queue_item(CMD_QUERY, rand64(), rand64());
      wait_idle();

      // one-word filter
      set_config(8'd4, 21'd64);
      a = rand64();
      b = rand64();
      queue_item(CMD_ADD, a, b);
      queue_item(CMD_QUERY, a, b);
      queue_item(CMD_QUERY, rand64(), rand64());
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0:       len = POS_W'($urandom_range(256, 1));
            1:       len = POS_W'($urandom);
            2:       len = FILTER_LENGTH_RST;
            default: len = POS_W'($urandom_range(65536, 1024));
         endcase
         set_config(NH_W'($urandom_range(12, 1)), len);
         gap_pct = gaps[p % 3];
         run_random(48);
         wait_idle();
      end

      repeat (200) @(posedge clock);
      if (err_count == 0 && resp_due_q.size() == 0) begin
         $display("bloom_filter_double_hash regression: pass");
      end else begin
         $display("bloom_filter_double_hash regression: fail");
      end
      $finish;
   end

   initial begin
      #50_000_000;
      $display("bloom_filter_double_hash regression: fail");
      $finish;
   end

endmodule

// ===== bloom_filter_double_hash.f =====
rtl/bfdh_pkg.sv
rtl/bfdh_ram.sv
rtl/bfdh_div.sv
rtl/bloom_filter_double_hash.sv
test/tb_bloom_filter_double_hash.sv
